[hdl/dfs_topological_order_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the DFS topological order unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DFS_TOPOLOGICAL_ORDER_UNIT_MACROS_SVH
`define DFS_TOPOLOGICAL_ORDER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, idle during reset.
`define DFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dfs_topological_order_unit: same-cycle check failed");
// Next-cycle implication, sampled on clk, idle during reset.
`define DFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dfs_topological_order_unit: next-cycle check failed");
`else
`define DFS_ASSERT_NOW(label, ante, cons)
`define DFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/dfs_topo_pkg.sv]
// ----------------------------------------------------------------------------
// DFS topological order package
// Sizes, codes and item types shared by the topological order unit.
// ----------------------------------------------------------------------------
package dfs_topo_pkg;

  localparam int MAX_NODES = 16;
  localparam int MAX_EDGES = 32;

  localparam int NODE_W   = $clog2(MAX_NODES);      // node index
  localparam int NCNT_W   = $clog2(MAX_NODES + 1);  // node count, stack pointer
  localparam int EADDR_W  = $clog2(MAX_EDGES);      // edge store address
  localparam int ECNT_W   = $clog2(MAX_EDGES + 1);  // edge count
  localparam int IDX_W    = 8;                      // raw node field of an edge

  // Item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SORT = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] from_node;
    logic [IDX_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] order_node;
    logic              node_valid;
    logic              status;
    logic              last;
  } out_item_t;

endpackage

[hdl/dfs_topological_order_unit.sv]
// ----------------------------------------------------------------------------
// DFS topological order unit
// A load item (mode 0) appends one directed edge to a 32-entry edge store;
// the unit stays ready. A sort item (mode 1) raises busy and runs a
// depth-first walk: roots in node order, edges in load order. Each edge test
// passes through ST_FETCH and then ST_CHECK because the edge store is a memory
// with a registered read port, and every node scans the whole edge list once
// from the saved position of its stack frame. Results then follow on
// out_strobe one per cycle, in topological order, and cannot be stalled; busy
// falls with the final result. A cycle, a walked edge with a destination
// outside node_total, an overflowed edge store or node_total above 16 give a
// single error result, which is registered from ST_ERR after the error is
// found. Every sort clears the edge store and the marks.
// ----------------------------------------------------------------------------
`include "dfs_topological_order_unit_macros.svh"

module dfs_topological_order_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  dfs_topo_pkg::in_item_t                in_item,
  input  logic                                  cfg_we,
  input  logic [dfs_topo_pkg::NCNT_W-1:0]       cfg_wdata,
  output logic                                  out_strobe,
  output dfs_topo_pkg::out_item_t               out_item
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_FETCH,
    ST_CHECK,
    ST_EMIT,
    ST_ERR
  } state_t;

  localparam int NODE_W  = dfs_topo_pkg::NODE_W;
  localparam int NCNT_W  = dfs_topo_pkg::NCNT_W;
  localparam int EADDR_W = dfs_topo_pkg::EADDR_W;
  localparam int ECNT_W  = dfs_topo_pkg::ECNT_W;
  localparam int IDX_W   = dfs_topo_pkg::IDX_W;
  localparam int NODES   = dfs_topo_pkg::MAX_NODES;
  localparam int EDGES   = dfs_topo_pkg::MAX_EDGES;

  state_t                  state_r;
  logic [NCNT_W-1:0]       node_total_r;
  logic [ECNT_W-1:0]       loaded_r;
  logic                    overflow_r;
  logic [NODES-1:0]        visited_r;
  logic [NODES-1:0]        on_path_r;
  logic [NCNT_W-1:0]       root_r;
  logic [NCNT_W-1:0]       sp_r;
  logic [NODE_W-1:0]       cur_u_r;
  logic [ECNT_W-1:0]       cur_e_r;
  logic [NCNT_W-1:0]       fc_r;
  logic [NODE_W-1:0]       stack_node_r [NODES];
  logic [ECNT_W-1:0]       stack_edge_r [NODES];
  logic [NODE_W-1:0]       finish_r     [NODES];
  logic                    out_strobe_r;
  dfs_topo_pkg::out_item_t out_item_r;

  // Edge store: source in the upper byte, destination in the lower byte.
  logic [2*IDX_W-1:0]      edge_mem [EDGES];
  logic [2*IDX_W-1:0]      rd_data_r;

  logic                    accept;
  logic                    mem_we;
  logic [IDX_W-1:0]        rd_src;
  logic [IDX_W-1:0]        rd_dst;
  logic [NODE_W-1:0]       dst_idx;
  logic [NODE_W-1:0]       root_idx;
  logic [NCNT_W-1:0]       sp_m1;
  logic [NCNT_W-1:0]       sp_m2;
  logic [NCNT_W-1:0]       fc_m1;

  assign accept   = start && (state_r == ST_IDLE);
  assign mem_we   = accept && (in_item.mode == dfs_topo_pkg::MODE_LOAD) &&
                    (loaded_r < ECNT_W'(EDGES));
  assign rd_src   = rd_data_r[2*IDX_W-1:IDX_W];
  assign rd_dst   = rd_data_r[IDX_W-1:0];
  assign dst_idx  = rd_dst[NODE_W-1:0];
  assign root_idx = root_r[NODE_W-1:0];
  assign sp_m1    = sp_r - NCNT_W'(1);
  assign sp_m2    = sp_r - NCNT_W'(2);
  assign fc_m1    = fc_r - NCNT_W'(1);

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      edge_mem[loaded_r[EADDR_W-1:0]] <= {in_item.from_node, in_item.to_node};
    end
    rd_data_r <= edge_mem[cur_e_r[EADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_total_r <= '0;
      loaded_r     <= '0;
      overflow_r   <= 1'b0;
      visited_r    <= '0;
      on_path_r    <= '0;
      root_r       <= '0;
      sp_r         <= '0;
      fc_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        node_total_r <= cfg_wdata;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_item.mode == dfs_topo_pkg::MODE_LOAD) begin
              if (mem_we) begin
                loaded_r <= loaded_r + ECNT_W'(1);
              end else begin
                overflow_r <= 1'b1;
              end
            end else if (overflow_r || (node_total_r > NCNT_W'(NODES))) begin
              state_r <= ST_ERR;
            end else begin
              root_r  <= '0;
              fc_r    <= '0;
              state_r <= ST_ROOT;
            end
          end
        end
        ST_ROOT: begin
          if (root_r == node_total_r) begin
            state_r <= ST_EMIT;
          end else if (visited_r[root_idx]) begin
            root_r <= root_r + NCNT_W'(1);
          end else begin
            stack_node_r[0]     <= root_idx;
            on_path_r[root_idx] <= 1'b1;
            sp_r                <= NCNT_W'(1);
            cur_u_r             <= root_idx;
            cur_e_r             <= '0;
            state_r             <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (cur_e_r < loaded_r) begin
            state_r <= ST_CHECK;
          end else begin
            // All edges of the top node are done: it finishes.
            on_path_r[cur_u_r]         <= 1'b0;
            visited_r[cur_u_r]         <= 1'b1;
            finish_r[fc_r[NODE_W-1:0]] <= cur_u_r;
            fc_r                       <= fc_r + NCNT_W'(1);
            sp_r                       <= sp_m1;
            if (sp_m1 == '0) begin
              state_r <= ST_ROOT;
            end else begin
              cur_u_r <= stack_node_r[sp_m2[NODE_W-1:0]];
              cur_e_r <= stack_edge_r[sp_m2[NODE_W-1:0]];
            end
          end
        end
        ST_CHECK: begin
          state_r <= ST_FETCH;
          cur_e_r <= cur_e_r + ECNT_W'(1);
          if (rd_src == IDX_W'(cur_u_r)) begin
            if ((rd_dst >= IDX_W'(node_total_r)) || on_path_r[dst_idx]) begin
              state_r <= ST_ERR;
            end else if (!visited_r[dst_idx]) begin
              stack_edge_r[sp_m1[NODE_W-1:0]] <= cur_e_r + ECNT_W'(1);
              stack_node_r[sp_r[NODE_W-1:0]]  <= dst_idx;
              on_path_r[dst_idx]              <= 1'b1;
              sp_r                            <= sp_r + NCNT_W'(1);
              cur_u_r                         <= dst_idx;
              cur_e_r                         <= '0;
            end
          end
        end
        ST_EMIT: begin
          out_strobe_r          <= 1'b1;
          out_item_r.status     <= dfs_topo_pkg::STATUS_OK;
          if (fc_r == '0) begin
            // Empty graph: one result that carries no node.
            out_item_r.order_node <= '0;
            out_item_r.node_valid <= 1'b0;
            out_item_r.last       <= 1'b1;
          end else begin
            out_item_r.order_node <= finish_r[fc_m1[NODE_W-1:0]];
            out_item_r.node_valid <= 1'b1;
            out_item_r.last       <= (fc_m1 == '0);
            fc_r                  <= fc_m1;
          end
          if (fc_r <= NCNT_W'(1)) begin
            visited_r  <= '0;
            on_path_r  <= '0;
            loaded_r   <= '0;
            overflow_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        ST_ERR: begin
          out_strobe_r          <= 1'b1;
          out_item_r.order_node <= '0;
          out_item_r.node_valid <= 1'b0;
          out_item_r.status     <= dfs_topo_pkg::STATUS_ERR;
          out_item_r.last       <= 1'b1;
          visited_r             <= '0;
          on_path_r             <= '0;
          loaded_r              <= '0;
          overflow_r            <= 1'b0;
          state_r               <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A node is never on the current path and finished at the same time.
  `DFS_ASSERT_NOW(a_marks_disjoint, 1'b1, (on_path_r & visited_r) == '0)
  // An error result is always the single, final result of a sort.
  `DFS_ASSERT_NOW(a_err_single, out_strobe && (out_item.status == dfs_topo_pkg::STATUS_ERR),
                  out_item.last && !out_item.node_valid)
  // A result that carries a node is never an error.
  `DFS_ASSERT_NOW(a_valid_ok, out_strobe && out_item.node_valid,
                  out_item.status == dfs_topo_pkg::STATUS_OK)
  // A sort item always keeps the unit busy for at least the next cycle.
  `DFS_ASSERT_NEXT(a_sort_busy, start && !busy && (in_item.mode == dfs_topo_pkg::MODE_SORT),
                   busy)

endmodule

[tb/sv/tb_dfs_topological_order_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the DFS topological order unit
// Loads edge lists and runs sorts through the command port, predicting every
// node order or error result with a behavioral depth-first walk kept in a
// small scoreboard, and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module tb_dfs_topological_order_unit;
  import dfs_topo_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 160;

  class topo_order_scoreboard;
    logic [NCNT_W-1:0] node_total;
    logic [IDX_W-1:0]  edge_src[MAX_EDGES];
    logic [IDX_W-1:0]  edge_dst[MAX_EDGES];
    int                edge_fill;
    bit                edge_overflow;
    int                finish_seq[MAX_NODES];
    int                finish_count;
    out_item_t         expected_order[$];
    int                errors;

    function new();
      node_total    = '0;
      edge_fill     = 0;
      edge_overflow = 0;
      errors        = 0;
    endfunction

    // Depth-first walk; fills finish_seq in finishing order, 0 on any error.
    function bit predict_sort();
      bit visited[MAX_NODES];
      bit on_path[MAX_NODES];
      int stack_node[MAX_NODES];
      int stack_next[MAX_NODES];
      int n, sp, u, e, d;
      bit pushed;
      n = int'(node_total);
      finish_count = 0;
      foreach (visited[i]) begin
        visited[i] = 0;
        on_path[i] = 0;
      end
      for (int root = 0; root < n; root++) begin
        if (visited[root]) continue;
        stack_node[0] = root;
        stack_next[0] = 0;
        on_path[root] = 1;
        sp = 1;
        while (sp > 0) begin
          u = stack_node[sp-1];
          e = stack_next[sp-1];
          pushed = 0;
          while (e < edge_fill) begin
            if (int'(edge_src[e]) != u) begin
              e++;
              continue;
            end
            d = int'(edge_dst[e]);
            if (d >= n) return 0;
            if (on_path[d]) return 0;
            e++;
            if (visited[d]) continue;
            stack_next[sp-1] = e;
            stack_node[sp] = d;
            stack_next[sp] = 0;
            on_path[d] = 1;
            sp++;
            pushed = 1;
            break;
          end
          if (!pushed) begin
            sp--;
            on_path[u] = 0;
            visited[u] = 1;
            finish_seq[finish_count] = u;
            finish_count++;
          end
        end
      end
      return 1;
    endfunction

    function void note_item(in_item_t it);
      out_item_t res;
      bit ok;
      if (it.mode == MODE_LOAD) begin
        if (edge_fill < MAX_EDGES) begin
          edge_src[edge_fill] = it.from_node;
          edge_dst[edge_fill] = it.to_node;
          edge_fill++;
        end else begin
          edge_overflow = 1;
        end
        return;
      end
      ok = !edge_overflow && (node_total <= MAX_NODES);
      if (ok) ok = predict_sort();
      edge_fill = 0;
      edge_overflow = 0;
      res = '0;
      res.last = 1'b1;
      if (!ok) begin
        res.status = STATUS_ERR;
        expected_order.push_back(res);
      end else if (finish_count == 0) begin
        res.status = STATUS_OK;
        expected_order.push_back(res);
      end else begin
        for (int k = 0; k < finish_count; k++) begin
          res.order_node = NODE_W'(finish_seq[finish_count-1-k]);
          res.node_valid = 1'b1;
          res.status     = STATUS_OK;
          res.last       = (k + 1 == finish_count);
          expected_order.push_back(res);
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_order.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_order.pop_front();
      if (got.order_node !== want.order_node) begin
        $display("%0t: order_node expected %0d, got %0d", $time, want.order_node,
                 got.order_node);
        errors++;
      end
      if (got.node_valid !== want.node_valid) begin
        $display("%0t: node_valid expected %0d, got %0d", $time, want.node_valid,
                 got.node_valid);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              cfg_we;
  logic [NCNT_W-1:0] cfg_wdata;
  logic              out_strobe;
  out_item_t         out_item;

  topo_order_scoreboard sb;
  int cycle_count = 0;
  int items_sent  = 0;
  int idle_pct    = 0;

  dfs_topological_order_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_edge(input int src, input int dst);
    in_item_t it;
    it           = '0;
    it.mode      = MODE_LOAD;
    it.from_node = IDX_W'(src);
    it.to_node   = IDX_W'(dst);
    send_item(it);
  endtask

  task automatic run_sort();
    in_item_t it;
    it           = '0;
    it.mode      = MODE_SORT;
    it.from_node = IDX_W'($urandom_range(0, 255));
    it.to_node   = IDX_W'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.expected_order.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_node_total(input int value);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = NCNT_W'(value);
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.node_total = NCNT_W'(value);
  endtask

  task automatic random_phase();
    int n, kind, count, a, b, j, tmp;
    int perm[MAX_NODES];
    n = int'(sb.node_total);
    kind = $urandom_range(0, 99);
    if (n >= 2 && n <= MAX_NODES && kind < 75) begin
      // Acyclic edges along a shuffled node order, with the odd broken edge.
      for (int i = 0; i < MAX_NODES; i++) perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_EDGES)
                                          : $urandom_range(0, 12);
      repeat (count) begin
        a = $urandom_range(0, n - 2);
        b = $urandom_range(a + 1, n - 1);
        load_edge(perm[a], perm[b]);
      end
      if ($urandom_range(0, 3) == 0) load_edge($urandom_range(n, 255), $urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0: begin
          a = $urandom_range(0, n - 2);
          b = $urandom_range(a + 1, n - 1);
          load_edge(perm[a], perm[b]);
          load_edge(perm[b], perm[a]);
        end
        1: load_edge(perm[$urandom_range(0, n - 1)], $urandom_range(n, 255));
        default: ;
      endcase
    end else if (kind < 80) begin
      repeat ($urandom_range(MAX_EDGES + 1, MAX_EDGES + 3))
        load_edge($urandom_range(0, 3), $urandom_range(0, 3));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 1)) load_edge($urandom_range(0, 255), $urandom_range(0, 255));
        else load_edge($urandom_range(0, 15), $urandom_range(0, 15));
      end
    end
    run_sort();
  endtask

  initial begin
    int random_base, pick;
    sb        = new();
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty graph.
    write_node_total(0);
    run_sort();
    // Small DAG with an edge whose source is out of range.
    write_node_total(4);
    load_edge(0, 1);
    load_edge(1, 2);
    load_edge(0, 3);
    load_edge(3, 2);
    load_edge(255, 0);
    run_sort();
    // Two-node cycle, then a self loop.
    load_edge(1, 2);
    load_edge(2, 1);
    run_sort();
    load_edge(2, 2);
    run_sort();
    // Walked edge with a destination outside the node count.
    load_edge(0, 255);
    run_sort();
    // Node count just above the limit.
    write_node_total(MAX_NODES + 1);
    run_sort();
    // Full node count: every node comes out.
    write_node_total(MAX_NODES);
    load_edge(15, 0);
    run_sort();
    write_node_total(31);
    run_sort();

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      if (items_sent - random_base < RANDOM_ITEMS / 3) idle_pct = 31;
      else if (items_sent - random_base < 2 * RANDOM_ITEMS / 3) idle_pct = 53;
      else idle_pct = 0;
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          case ($urandom_range(0, 4))
            0: write_node_total(0);
            1: write_node_total(1);
            2: write_node_total(MAX_NODES);
            3: write_node_total(MAX_NODES + 1);
            default: write_node_total(31);
          endcase
        end else begin
          write_node_total($urandom_range(2, MAX_NODES));
        end
      end
      random_phase();
    end

    wait_drained();
    if (sb.errors == 0 && sb.expected_order.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
